[sv/fuser_pkg.sv]
// Shared types and constants of the framed UART byte serializer.
// Used by fuser_front, fuser_cmdq, fuser_back and framed_uart_byte_serializer.
package fuser_pkg;

  localparam int unsigned DataBits     = 8;
  localparam int unsigned PosWidth     = 4;
  localparam int unsigned GapWidth     = 3;
  localparam int unsigned GapMax       = 4;
  localparam int unsigned SlotWidth    = 4;
  localparam int unsigned CfgAddrWidth = 2;
  localparam int unsigned CfgDataWidth = 8;
  localparam int unsigned NumAnglesDef = 5;
  localparam int unsigned CmdDepthDef  = 2;

  localparam logic [DataBits-1:0] ResetStartMarker = 8'd181;
  localparam logic [DataBits-1:0] ResetEndMarker   = 8'd255;
  localparam logic [GapWidth-1:0] ResetGapSlots    = 3'd2;

  typedef enum logic [CfgAddrWidth-1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1,
    REG_GAP_SLOTS    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [DataBits-1:0] angle;
    logic                send_start;
    logic                send_end;
  } cmd_t;

endpackage

[sv/fuser_front.sv]
// Front end: tracks the position in the frame and classifies each angle.
// Depends on fuser_pkg for cmd_t and widths.
module fuser_front #(
  parameter int unsigned NumAngles = fuser_pkg::NumAnglesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [fuser_pkg::DataBits-1:0]    angle_i,
  output fuser_pkg::cmd_t                   cmd_o
);

  localparam int unsigned CmpWidth = fuser_pkg::PosWidth + 1;

  logic [fuser_pkg::PosWidth-1:0] pos_q, pos_d;
  logic [CmpWidth-1:0]            pos_next;
  logic                           is_last;

  assign pos_next = {1'b0, pos_q} + CmpWidth'(1);
  assign is_last  = pos_next >= CmpWidth'(NumAngles);

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      pos_d = is_last ? '0 : pos_next[fuser_pkg::PosWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign cmd_o.angle      = angle_i;
  assign cmd_o.send_start = (pos_q == '0);
  assign cmd_o.send_end   = is_last;

endmodule

[sv/fuser_cmdq.sv]
// Short command queue between the front end and the serializer.
// Depends on fuser_pkg for cmd_t.
module fuser_cmdq #(
  parameter int unsigned Depth = fuser_pkg::CmdDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fuser_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output fuser_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fuser_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/fuser_back.sv]
// Back end: holds the configuration and turns each command into bit slots.
// Depends on fuser_pkg for cmd_t, register indexes and widths.
module fuser_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fuser_pkg::CfgAddrWidth-1:0]   cfg_addr_i,
  input  logic [fuser_pkg::CfgDataWidth-1:0]   cfg_wdata_i,
  input  logic                                 cmd_valid_i,
  input  fuser_pkg::cmd_t                      cmd_i,
  output logic                                 cmd_pop_o,
  input  logic                                 pop_i,
  output logic                                 empty_o,
  output logic                                 line_level_o,
  output logic                                 last_slot_o
);

  typedef enum logic [1:0] {
    CH_START,
    CH_ANGLE,
    CH_END
  } ch_e;

  localparam int unsigned SW = fuser_pkg::SlotWidth;

  logic [fuser_pkg::DataBits-1:0] start_marker_q, end_marker_q;
  logic [fuser_pkg::GapWidth-1:0] gap_slots_q;

  ch_e                            ch_q, eff_ch;
  logic [SW-1:0]                  slot_q;
  logic                           out_valid_q, out_level_q, out_last_q;

  logic [fuser_pkg::GapWidth-1:0] gap_eff;
  logic [SW-1:0]                  char_end;
  logic [fuser_pkg::DataBits-1:0] cur_byte;
  logic [2:0]                     bit_idx;
  logic                           advance, char_done, slot_level, slot_last;

  assign gap_eff  = (gap_slots_q > fuser_pkg::GapWidth'(fuser_pkg::GapMax)) ?
                    fuser_pkg::GapWidth'(fuser_pkg::GapMax) : gap_slots_q;
  assign char_end = SW'(fuser_pkg::DataBits + 1) + SW'(gap_eff);
  assign eff_ch   = (ch_q == CH_START && !cmd_i.send_start) ? CH_ANGLE : ch_q;
  assign advance  = cmd_valid_i && (!out_valid_q || pop_i);
  assign char_done = (slot_q == char_end);
  assign bit_idx  = 3'(slot_q - SW'(1));

  always_comb begin
    unique case (eff_ch)
      CH_START: cur_byte = start_marker_q;
      CH_ANGLE: cur_byte = cmd_i.angle;
      CH_END:   cur_byte = end_marker_q;
      default:  cur_byte = cmd_i.angle;
    endcase
  end

  always_comb begin
    priority if (slot_q == '0) begin
      slot_level = 1'b0;
    end else if (slot_q <= SW'(fuser_pkg::DataBits)) begin
      slot_level = cur_byte[bit_idx];
    end else begin
      slot_level = 1'b1;
    end
  end

  assign slot_last = char_done &&
                     (eff_ch == CH_END || (eff_ch == CH_ANGLE && !cmd_i.send_end));
  assign cmd_pop_o = advance && slot_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= fuser_pkg::ResetStartMarker;
      end_marker_q   <= fuser_pkg::ResetEndMarker;
      gap_slots_q    <= fuser_pkg::ResetGapSlots;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        fuser_pkg::REG_START_MARKER: start_marker_q <= cfg_wdata_i;
        fuser_pkg::REG_END_MARKER:   end_marker_q   <= cfg_wdata_i;
        fuser_pkg::REG_GAP_SLOTS:    gap_slots_q    <= cfg_wdata_i[fuser_pkg::GapWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= CH_START;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      out_level_q <= 1'b1;
      out_last_q  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        out_level_q <= slot_level;
        out_last_q  <= slot_last;
        if (!char_done) begin
          slot_q <= slot_q + SW'(1);
        end else begin
          slot_q <= '0;
          unique case (eff_ch)
            CH_START: ch_q <= CH_ANGLE;
            CH_ANGLE: ch_q <= cmd_i.send_end ? CH_END : CH_START;
            CH_END:   ch_q <= CH_START;
            default:  ch_q <= CH_START;
          endcase
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o      = !out_valid_q;
  assign line_level_o = out_level_q;
  assign last_slot_o  = out_last_q;

`ifndef ASSERT_OFF
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SW'(fuser_pkg::DataBits + 1 + fuser_pkg::GapMax))
    else $error("slot counter out of range");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (out_valid_q && out_last_q))
    else $error("command retired without a last slot");

  a_last_is_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> out_level_q)
    else $error("last slot not at mark level");

  a_start_bit_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && slot_q == '0) |=> !out_level_q)
    else $error("start bit not low");
`endif

endmodule

[sv/framed_uart_byte_serializer.sv]
// Framed UART byte serializer: each accepted angle becomes the bit slots of
// an 8N1 character, one slot per result, with the start marker before the
// first angle of a frame and the end marker after the last one. A character
// is 10 slots plus gap_slots idle-high slots (clamped to 4), so an item gives
// 10 to 42 results; the serializer issues one slot per cycle from its output
// register while pop is held and a command is queued. A two-entry
// command queue lets new angles be accepted while earlier ones are serialized.
// Depends on fuser_pkg, fuser_front, fuser_cmdq and fuser_back.
module framed_uart_byte_serializer #(
  parameter int unsigned NumAngles = fuser_pkg::NumAnglesDef,
  parameter int unsigned CmdDepth  = fuser_pkg::CmdDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fuser_pkg::CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [fuser_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                               push,
  output logic                               full,
  input  logic [fuser_pkg::DataBits-1:0]     angle_i,
  output logic                               empty,
  input  logic                               pop,
  output logic                               line_level_o,
  output logic                               last_slot_o
);

  fuser_pkg::cmd_t front_cmd, head_cmd;
  logic            accept, head_valid, head_pop;

  assign accept = push && !full;

  fuser_front #(
    .NumAngles (NumAngles)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .angle_i  (angle_i),
    .cmd_o    (front_cmd)
  );

  fuser_cmdq #(
    .Depth (CmdDepth)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  fuser_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_valid_i  (head_valid),
    .cmd_i        (head_cmd),
    .cmd_pop_o    (head_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .line_level_o (line_level_o),
    .last_slot_o  (last_slot_o)
  );

endmodule

[dv/framed_uart_byte_serializer_test.sv]
// Testbench of framed_uart_byte_serializer: drives angle bytes and register writes, predicts
// every 8N1 bit slot with its own frame model and checks each popped slot against it.
// Depends on fuser_pkg and framed_uart_byte_serializer.
module framed_uart_byte_serializer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumAnglesTb = 5;
  localparam int unsigned IdlePct     = 38;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned RandPhases  = 5;
  localparam int unsigned PhaseItems  = 100;
  localparam logic [fuser_pkg::CfgAddrWidth-1:0] RegUnmapped = 2'd3;

  typedef enum logic { ROW_WRITE, ROW_ANGLE } row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [1:0]                     addr;
    logic [fuser_pkg::DataBits-1:0] data;
    logic [5:0]                     slots;
  } row_t;

  typedef struct packed {
    logic level;
    logic last;
  } line_slot_t;

  // slots typed in where the count is obvious, 0 where the frame model decides
  localparam row_t DirectedRows [31] = '{
    '{ROW_ANGLE, 2'd0, 8'h00, 6'd24},
    '{ROW_ANGLE, 2'd0, 8'hFF, 6'd12},
    '{ROW_ANGLE, 2'd0, 8'h01, 6'd12},
    '{ROW_ANGLE, 2'd0, 8'h80, 6'd12},
    '{ROW_ANGLE, 2'd0, 8'h55, 6'd24},
    '{ROW_WRITE, fuser_pkg::REG_GAP_SLOTS,    8'h00, 6'd0},
    '{ROW_WRITE, fuser_pkg::REG_START_MARKER, 8'h00, 6'd0},
    '{ROW_WRITE, fuser_pkg::REG_END_MARKER,   8'h00, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'hAA, 6'd20},
    '{ROW_ANGLE, 2'd0, 8'h5A, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'hA5, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'h0F, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'hF0, 6'd20},
    '{ROW_WRITE, fuser_pkg::REG_GAP_SLOTS,    8'h07, 6'd0},
    '{ROW_WRITE, fuser_pkg::REG_START_MARKER, 8'hFF, 6'd0},
    '{ROW_WRITE, fuser_pkg::REG_END_MARKER,   8'hFF, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'h00, 6'd28},
    '{ROW_ANGLE, 2'd0, 8'hFF, 6'd14},
    '{ROW_ANGLE, 2'd0, 8'h33, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'hCC, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'h7E, 6'd28},
    '{ROW_WRITE, RegUnmapped,                 8'h00, 6'd0},
    '{ROW_WRITE, fuser_pkg::REG_GAP_SLOTS,    8'h04, 6'd0},
    '{ROW_WRITE, fuser_pkg::REG_END_MARKER,   8'h3C, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'hC3, 6'd28},
    '{ROW_ANGLE, 2'd0, 8'h96, 6'd14},
    '{ROW_WRITE, fuser_pkg::REG_GAP_SLOTS,    8'h05, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'h69, 6'd0},
    '{ROW_WRITE, fuser_pkg::REG_GAP_SLOTS,    8'h01, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'h01, 6'd0},
    '{ROW_ANGLE, 2'd0, 8'hFE, 6'd0}
  };

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_we_i = 1'b0;
  logic [fuser_pkg::CfgAddrWidth-1:0] cfg_addr_i = '0;
  logic [fuser_pkg::CfgDataWidth-1:0] cfg_wdata_i = '0;
  logic                               push = 1'b0;
  logic                               full;
  logic [fuser_pkg::DataBits-1:0]     angle_i = '0;
  logic                               empty;
  logic                               pop = 1'b0;
  logic                               line_level_o;
  logic                               last_slot_o;

  logic [fuser_pkg::DataBits-1:0] start_mark = fuser_pkg::ResetStartMarker;
  logic [fuser_pkg::DataBits-1:0] end_mark   = fuser_pkg::ResetEndMarker;
  logic [fuser_pkg::GapWidth-1:0] gap_cfg    = fuser_pkg::ResetGapSlots;
  logic [fuser_pkg::PosWidth-1:0] frame_pos  = '0;

  line_slot_t  line_slots_q [$];
  int unsigned byte_len_q [$];
  int unsigned slots_in_byte = 0;
  int unsigned stall_cycles = 0;
  int unsigned errors = 0;
  bit          calm = 1'b0;

  framed_uart_byte_serializer #(
    .NumAngles(NumAnglesTb)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .angle_i     (angle_i),
    .empty       (empty),
    .pop         (pop),
    .line_level_o(line_level_o),
    .last_slot_o (last_slot_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= 40) begin
      $display("%0t ns mismatch %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  function automatic void add_char(ref line_slot_t chars [$],
                                   input logic [fuser_pkg::DataBits-1:0] b);
    int unsigned gap;
    gap = (gap_cfg > fuser_pkg::GapMax) ? fuser_pkg::GapMax : gap_cfg;
    chars.push_back('{level: 1'b0, last: 1'b0});
    for (int i = 0; i < fuser_pkg::DataBits; i++) begin
      chars.push_back('{level: b[i], last: 1'b0});
    end
    for (int i = 0; i <= gap; i++) begin
      chars.push_back('{level: 1'b1, last: 1'b0});
    end
  endfunction

  function automatic int unsigned serialize_angle(input logic [fuser_pkg::DataBits-1:0] ang);
    line_slot_t chars [$];
    if (frame_pos == 0) begin
      add_char(chars, start_mark);
    end
    add_char(chars, ang);
    if (int'(frame_pos) + 1 >= NumAnglesTb) begin
      add_char(chars, end_mark);
      frame_pos = '0;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
    chars[chars.size() - 1].last = 1'b1;
    foreach (chars[i]) begin
      line_slots_q.push_back(chars[i]);
    end
    return chars.size();
  endfunction

  task automatic send_angle(input logic [fuser_pkg::DataBits-1:0] ang,
                            input int unsigned typed_len);
    int unsigned len;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IdlePct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    angle_i <= ang;
    do @(posedge clk_i); while (full);
    len = serialize_angle(ang);
    byte_len_q.push_back(typed_len != 0 ? typed_len : len);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    push <= 1'b0;
    while (line_slots_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [fuser_pkg::CfgAddrWidth-1:0] idx,
                           input logic [fuser_pkg::CfgDataWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      fuser_pkg::REG_START_MARKER: start_mark = val;
      fuser_pkg::REG_END_MARKER:   end_mark = val;
      fuser_pkg::REG_GAP_SLOTS:    gap_cfg = val[fuser_pkg::GapWidth-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    pop <= calm || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin : check_slots
    line_slot_t want;
    int unsigned len;
    if (rst_ni && pop && !empty) begin
      slots_in_byte++;
      if (line_slots_q.size() == 0) begin
        report("slot with nothing expected", line_level_o, -1);
      end else begin
        want = line_slots_q.pop_front();
        if (line_level_o !== want.level) report("line_level", line_level_o, want.level);
        if (last_slot_o !== want.last) report("last_slot", last_slot_o, want.last);
      end
      if (last_slot_o === 1'b1) begin
        if (byte_len_q.size() != 0) begin
          len = byte_len_q.pop_front();
          if (slots_in_byte != len) report("slots per angle", slots_in_byte, len);
        end
        slots_in_byte = 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("framed_uart_byte_serializer_test: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [fuser_pkg::DataBits-1:0] s_mark, e_mark;
    logic [fuser_pkg::GapWidth-1:0] gap;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[r]) begin
      if (DirectedRows[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(DirectedRows[r].addr, DirectedRows[r].data);
      end else begin
        send_angle(DirectedRows[r].data, DirectedRows[r].slots);
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: begin
          gap = 3'd0; s_mark = 8'h00; e_mark = 8'hFF;
        end
        1: begin
          gap = 3'd7; s_mark = 8'hFF; e_mark = 8'h00;
        end
        default: begin
          gap    = 3'($urandom_range(7));
          s_mark = 8'($urandom_range(255));
          e_mark = 8'($urandom_range(255));
        end
      endcase
      wait_idle();
      calm = (p == 2);
      write_reg(fuser_pkg::REG_START_MARKER, s_mark);
      write_reg(fuser_pkg::REG_END_MARKER, e_mark);
      write_reg(fuser_pkg::REG_GAP_SLOTS, 8'(gap));
      write_reg(RegUnmapped, 8'($urandom_range(255)));
      for (int i = 0; i < PhaseItems; i++) begin
        send_angle(8'($urandom_range(255)), 0);
      end
    end

    wait_idle();
    calm = 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("framed_uart_byte_serializer_test: done, clean");
    end else begin
      $display("framed_uart_byte_serializer_test: done, errors");
    end
    $finish;
  end

endmodule
